[sv/brd_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear RGB565 downscaler package
// Shared types and fixed field widths of the downscaler.
// ----------------------------------------------------------------------------
package brd_pkg;

   localparam int PIXEL_W  = 16;
   localparam int INDEX_W  = 15;
   localparam int OUT_X_W  = 7;
   localparam int OUT_Y_W  = 6;
   localparam int RATIO_W  = 27;
   localparam int RATIO_FRAC = 16;

   localparam int RED_LSB   = 11;
   localparam int GREEN_LSB = 5;
   localparam int RB_W      = 5;
   localparam int G_W       = 6;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_SCALE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_ROW,
      ST_READ,
      ST_ACC,
      ST_DONE
   } brd_state_type;

endpackage

[sv/bilinear_rgb565_downscaler_top.sv]
// ----------------------------------------------------------------------------
// Bilinear RGB565 downscaler
// Holds one source frame and returns bilinear interpolated output pixels.
// ----------------------------------------------------------------------------
// A write request (func 0) gives no response; busy stays low. A pixel request
// (func 1) runs through ST_LOCATE and ST_ROW, which find the source position
// and row, then through ST_READ and ST_ACC for each of the four neighbours,
// which are read one at a time from the frame memory and weighted by one
// multiply-accumulate per colour channel, shared by the four neighbours, and
// ends in ST_DONE, which packs the result. Busy falls in the strobe cycle, so
// a new pixel request is taken only once the last one is through. The response
// is shown for one cycle only and cannot be stalled.
module bilinear_rgb565_downscaler_top #(
   parameter int SRC_WIDTH  = 160,
   parameter int SRC_HEIGHT = 144,
   parameter int OUT_WIDTH  = 80,
   parameter int OUT_HEIGHT = 64,
   parameter int FRAC_BITS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [brd_pkg::PIXEL_W-1:0]   req_src_pixel,
   input  logic [brd_pkg::INDEX_W-1:0]   req_src_index,
   input  logic [brd_pkg::OUT_X_W-1:0]   req_out_x,
   input  logic [brd_pkg::OUT_Y_W-1:0]   req_out_y,
   output logic                          rsp_strobe,
   output logic [brd_pkg::PIXEL_W-1:0]   rsp_out_pixel
);
   import brd_pkg::*;

   localparam int DEPTH  = SRC_WIDTH * SRC_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
   localparam int XW     = $clog2(SRC_WIDTH);
   localparam int YW     = $clog2(SRC_HEIGHT);
   localparam int POSX_W = OUT_X_W + RATIO_W;
   localparam int POSY_W = OUT_Y_W + RATIO_W;
   localparam int IPX_W  = POSX_W - RATIO_FRAC;
   localparam int IPY_W  = POSY_W - RATIO_FRAC;
   localparam int FW     = FRAC_BITS + 1;
   localparam int WW     = 2 * FRAC_BITS + 1;
   localparam int ACC_W  = G_W + 2 * FRAC_BITS;

   localparam logic [RATIO_W-1:0] RATIO_X = RATIO_W'((SRC_WIDTH << 16) / OUT_WIDTH);
   localparam logic [RATIO_W-1:0] RATIO_Y = RATIO_W'((SRC_HEIGHT << 16) / OUT_HEIGHT);
   localparam logic [IPX_W-1:0]   X_LAST_IP = IPX_W'(SRC_WIDTH - 1);
   localparam logic [IPY_W-1:0]   Y_LAST_IP = IPY_W'(SRC_HEIGHT - 1);
   localparam logic [XW-1:0]      X_LAST = XW'(SRC_WIDTH - 1);
   localparam logic [YW-1:0]      Y_LAST = YW'(SRC_HEIGHT - 1);
   localparam logic [IDX_W-1:0]   DEPTH_IDX = IDX_W'(DEPTH);
   localparam logic [ADDR_W-1:0]  ROW_STEP = ADDR_W'(SRC_WIDTH);
   localparam logic [FW-1:0]      WEIGHT_ONE = FW'(1) << FRAC_BITS;

   logic [PIXEL_W-1:0] frame_mem [DEPTH];

   brd_state_type            state_ff, state_in;
   logic [OUT_X_W-1:0]       x_ff;
   logic [OUT_Y_W-1:0]       y_ff;
   logic [XW-1:0]            xv_ff, xv_in;
   logic [YW-1:0]            yv_ff, yv_in;
   logic [FRAC_BITS-1:0]     fx_ff, fx_in, fy_ff, fy_in;
   logic                     x_step_ff, x_step_in, y_step_ff, y_step_in;
   logic [ADDR_W-1:0]        row_ff, row_in;
   logic [1:0]               nb_ff;
   logic [WW-1:0]            weight_ff, weight_in;
   logic [PIXEL_W-1:0]       rd_data_ff;
   logic [ACC_W-1:0]         acc_r_ff, acc_g_ff, acc_b_ff;
   logic                     rsp_strobe_ff;
   logic [PIXEL_W-1:0]       rsp_pixel_ff, pixel_in;

   logic                     accept;
   logic                     do_write;
   logic [IDX_W-1:0]         write_idx;
   logic [POSX_W-1:0]        pos_x;
   logic [POSY_W-1:0]        pos_y;
   logic [IPX_W-1:0]         ip_x;
   logic [IPY_W-1:0]         ip_y;
   logic [ADDR_W-1:0]        rd_addr;
   logic [FW-1:0]            h_weight, v_weight;
   logic [RB_W-1:0]          red_c, blue_c;
   logic [G_W-1:0]           green_c;
   logic [ACC_W-1:0]         acc_r_in, acc_g_in, acc_b_in;
   logic [RB_W-1:0]          red_o, blue_o;
   logic [G_W-1:0]           green_o;
   logic [PIXEL_W-1:0]       color;

   assign accept    = start && !busy;
   assign write_idx = IDX_W'(req_src_index);
   assign do_write  = accept && (req_func == FUNC_WRITE) && (write_idx < DEPTH_IDX);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && (req_func == FUNC_SCALE)) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: state_in = ST_ROW;
         ST_ROW:    state_in = ST_READ;
         ST_READ:   state_in = ST_ACC;
         ST_ACC: begin
            state_in = (nb_ff == 2'd3) ? ST_DONE : ST_READ;
         end
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         default: busy = 1'b1;
      endcase
   end

   always_comb begin
      pos_x     = POSX_W'(x_ff) * POSX_W'(RATIO_X);
      pos_y     = POSY_W'(y_ff) * POSY_W'(RATIO_Y);
      ip_x      = pos_x[POSX_W-1:RATIO_FRAC];
      ip_y      = pos_y[POSY_W-1:RATIO_FRAC];
      fx_in     = pos_x[RATIO_FRAC-1 -: FRAC_BITS];
      fy_in     = pos_y[RATIO_FRAC-1 -: FRAC_BITS];
      xv_in     = (ip_x > X_LAST_IP) ? X_LAST : ip_x[XW-1:0];
      yv_in     = (ip_y > Y_LAST_IP) ? Y_LAST : ip_y[YW-1:0];
      x_step_in = (xv_in != X_LAST);
      y_step_in = (yv_in != Y_LAST);
   end

   assign row_in = ADDR_W'(yv_ff) * ROW_STEP;

   always_comb begin
      rd_addr = row_ff + ADDR_W'(xv_ff);
      if (nb_ff[0] && x_step_ff) begin
         rd_addr = rd_addr + ADDR_W'(1);
      end
      if (nb_ff[1] && y_step_ff) begin
         rd_addr = rd_addr + ROW_STEP;
      end
      h_weight  = nb_ff[0] ? FW'(fx_ff) : (WEIGHT_ONE - FW'(fx_ff));
      v_weight  = nb_ff[1] ? FW'(fy_ff) : (WEIGHT_ONE - FW'(fy_ff));
      weight_in = WW'(h_weight) * WW'(v_weight);
   end

   always_comb begin
      red_c    = rd_data_ff[RED_LSB +: RB_W];
      green_c  = rd_data_ff[GREEN_LSB +: G_W];
      blue_c   = rd_data_ff[0 +: RB_W];
      acc_r_in = acc_r_ff + ACC_W'(red_c) * ACC_W'(weight_ff);
      acc_g_in = acc_g_ff + ACC_W'(green_c) * ACC_W'(weight_ff);
      acc_b_in = acc_b_ff + ACC_W'(blue_c) * ACC_W'(weight_ff);
      red_o    = acc_r_ff[2*FRAC_BITS +: RB_W];
      green_o  = acc_g_ff[2*FRAC_BITS +: G_W];
      blue_o   = acc_b_ff[2*FRAC_BITS +: RB_W];
      color    = {red_o, green_o, blue_o};
      pixel_in = {color[7:0], color[15:8]};
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         frame_mem[write_idx[ADDR_W-1:0]] <= req_src_pixel;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_out_x;
         y_ff <= req_out_y;
      end
      if (state_ff == ST_LOCATE) begin
         xv_ff     <= xv_in;
         yv_ff     <= yv_in;
         fx_ff     <= fx_in;
         fy_ff     <= fy_in;
         x_step_ff <= x_step_in;
         y_step_ff <= y_step_in;
      end
      if (state_ff == ST_ROW) begin
         row_ff   <= row_in;
         acc_r_ff <= '0;
         acc_g_ff <= '0;
         acc_b_ff <= '0;
      end
      if (state_ff == ST_READ) begin
         weight_ff <= weight_in;
      end
      if (state_ff == ST_ACC) begin
         acc_r_ff <= acc_r_in;
         acc_g_ff <= acc_g_in;
         acc_b_ff <= acc_b_in;
      end
      if (state_ff == ST_DONE) begin
         rsp_pixel_ff <= pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         nb_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_DONE);
         if (state_ff == ST_ROW) begin
            nb_ff <= '0;
         end else if (state_ff == ST_ACC) begin
            nb_ff <= nb_ff + 2'd1;
         end
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_pixel = rsp_pixel_ff;

endmodule

[sim/bilinear_rgb565_downscaler_top_tb.sv]
// ----------------------------------------------------------------------------
// Bilinear RGB565 downscaler testbench
// Fills parts of the source frame and checks every interpolated output pixel
// against a predictor that keeps its own frame copy. Pixel requests only
// touch source pixels that have been written before them.
// ----------------------------------------------------------------------------
module bilinear_rgb565_downscaler_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import brd_pkg::*;

   localparam int CLK_PERIOD   = 4;
   localparam int SRC_W        = 160;
   localparam int SRC_H        = 144;
   localparam int DST_W        = 80;
   localparam int DST_H        = 64;
   localparam int WEIGHT_BITS  = 8;
   localparam int FRAME_DEPTH  = SRC_W * SRC_H;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic                 func;
      logic [PIXEL_W-1:0]   pixel;
      logic [INDEX_W-1:0]   index;
      logic [OUT_X_W-1:0]   out_x;
      logic [OUT_Y_W-1:0]   out_y;
   } request_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_func = FUNC_WRITE;
   logic [PIXEL_W-1:0]   req_src_pixel = '0;
   logic [INDEX_W-1:0]   req_src_index = '0;
   logic [OUT_X_W-1:0]   req_out_x = '0;
   logic [OUT_Y_W-1:0]   req_out_y = '0;
   logic                 rsp_strobe;
   logic [PIXEL_W-1:0]   rsp_out_pixel;

   request_type          pending_requests[$];
   logic [PIXEL_W-1:0]   expected_pixels[$];
   logic [PIXEL_W-1:0]   frame_model[FRAME_DEPTH];
   bit                   frame_written[FRAME_DEPTH];
   int unsigned          useful_items = 0;
   int unsigned          mismatches = 0;
   int unsigned          gap_left = 0;
   bit                   steady = 1'b0;

   bilinear_rgb565_downscaler_top #(
      .SRC_WIDTH (SRC_W),
      .SRC_HEIGHT(SRC_H),
      .OUT_WIDTH (DST_W),
      .OUT_HEIGHT(DST_H),
      .FRAC_BITS (WEIGHT_BITS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_src_pixel(req_src_pixel),
      .req_src_index(req_src_index),
      .req_out_x    (req_out_x),
      .req_out_y    (req_out_y),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_pixel(rsp_out_pixel)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Splits one output coordinate into a clamped source position and weight.
   function automatic void locate_axis(input int unsigned coord, input int unsigned src_n,
                                       input int unsigned dst_n, output int unsigned ipart,
                                       output int unsigned frac);
      longint unsigned ratio;
      longint unsigned pos;
      ratio = (64'(src_n) << RATIO_FRAC) / 64'(dst_n);
      pos   = 64'(coord) * ratio;
      frac  = int'((pos >> (RATIO_FRAC - WEIGHT_BITS)) & ((64'd1 << WEIGHT_BITS) - 1));
      ipart = ((pos >> RATIO_FRAC) > 64'(src_n - 1)) ? src_n - 1 : int'(pos >> RATIO_FRAC);
   endfunction

   function automatic void tap_positions(input int unsigned ox, input int unsigned oy,
                                         output int unsigned ia, output int unsigned ib,
                                         output int unsigned ic, output int unsigned id,
                                         output int unsigned f, output int unsigned g);
      int unsigned x0, y0, x1, y1;
      locate_axis(ox, SRC_W, DST_W, x0, f);
      locate_axis(oy, SRC_H, DST_H, y0, g);
      x1 = (x0 + 1 < SRC_W) ? x0 + 1 : SRC_W - 1;
      y1 = (y0 + 1 < SRC_H) ? y0 + 1 : SRC_H - 1;
      ia = y0 * SRC_W + x0;
      ib = y0 * SRC_W + x1;
      ic = y1 * SRC_W + x0;
      id = y1 * SRC_W + x1;
   endfunction

   function automatic int unsigned blend_channel(input int unsigned a, input int unsigned b,
                                                 input int unsigned c, input int unsigned d,
                                                 input int unsigned f, input int unsigned g);
      longint unsigned nf, ng, acc;
      nf  = (64'd1 << WEIGHT_BITS) - 64'(f);
      ng  = (64'd1 << WEIGHT_BITS) - 64'(g);
      acc = 64'(a) * nf * ng + 64'(b) * 64'(f) * ng
          + 64'(c) * nf * 64'(g) + 64'(d) * 64'(f) * 64'(g);
      return int'(acc >> (2 * WEIGHT_BITS));
   endfunction

   function automatic logic [PIXEL_W-1:0] scaled_pixel(input int unsigned ox,
                                                       input int unsigned oy);
      int unsigned        ia, ib, ic, id, f, g, red, grn, blu;
      logic [PIXEL_W-1:0] pa, pb, pc, pd, packed_px;
      tap_positions(ox, oy, ia, ib, ic, id, f, g);
      pa  = frame_model[ia];
      pb  = frame_model[ib];
      pc  = frame_model[ic];
      pd  = frame_model[id];
      red = blend_channel(pa[RED_LSB +: RB_W], pb[RED_LSB +: RB_W],
                          pc[RED_LSB +: RB_W], pd[RED_LSB +: RB_W], f, g);
      grn = blend_channel(pa[GREEN_LSB +: G_W], pb[GREEN_LSB +: G_W],
                          pc[GREEN_LSB +: G_W], pd[GREEN_LSB +: G_W], f, g);
      blu = blend_channel(pa[0 +: RB_W], pb[0 +: RB_W], pc[0 +: RB_W], pd[0 +: RB_W], f, g);
      packed_px = {red[RB_W-1:0], grn[G_W-1:0], blu[RB_W-1:0]};
      return {packed_px[7:0], packed_px[15:8]};
   endfunction

   function automatic void add_write(input int unsigned idx, input logic [PIXEL_W-1:0] px);
      request_type item;
      item.func  = FUNC_WRITE;
      item.pixel = px;
      item.index = INDEX_W'(idx);
      item.out_x = OUT_X_W'($urandom);
      item.out_y = OUT_Y_W'($urandom);
      pending_requests.push_back(item);
      if (idx < FRAME_DEPTH) begin
         frame_written[idx] = 1'b1;
         useful_items++;
      end
   endfunction

   // Any neighbour not yet written gets a random pixel first.
   function automatic void add_scale(input int unsigned ox, input int unsigned oy);
      request_type item;
      int unsigned ia, ib, ic, id, f, g;
      tap_positions(ox, oy, ia, ib, ic, id, f, g);
      if (!frame_written[ia]) add_write(ia, PIXEL_W'($urandom));
      if (!frame_written[ib]) add_write(ib, PIXEL_W'($urandom));
      if (!frame_written[ic]) add_write(ic, PIXEL_W'($urandom));
      if (!frame_written[id]) add_write(id, PIXEL_W'($urandom));
      item.func  = FUNC_SCALE;
      item.pixel = PIXEL_W'($urandom);
      item.index = INDEX_W'($urandom);
      item.out_x = OUT_X_W'(ox);
      item.out_y = OUT_Y_W'(oy);
      pending_requests.push_back(item);
      useful_items++;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if ($urandom_range(0, 49) == 0) steady = ~steady;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   initial begin
      int unsigned roll, ia, ib, ic, id, f, g;
      add_write(0, 16'hffff);
      add_write(1, 16'hffff);
      add_write(SRC_W, 16'hffff);
      add_write(SRC_W + 1, 16'hffff);
      add_scale(0, 0);
      add_write(0, 16'hf800);
      add_scale(0, 0);
      add_write(FRAME_DEPTH - 1, 16'h0000);
      add_write(FRAME_DEPTH, 16'h07e0);
      add_write((1 << INDEX_W) - 1, 16'h001f);
      add_scale(1, 1);
      add_scale(DST_W - 1, DST_H - 1);
      add_scale((1 << OUT_X_W) - 1, DST_H - 1);
      add_scale(0, DST_H - 1);
      add_scale((1 << OUT_X_W) - 1, 0);
      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            add_scale($urandom_range(0, (1 << OUT_X_W) - 1), $urandom_range(0, DST_H - 1));
         end else if (roll < 78) begin
            tap_positions($urandom_range(0, (1 << OUT_X_W) - 1), $urandom_range(0, DST_H - 1),
                          ia, ib, ic, id, f, g);
            case ($urandom_range(0, 3))
               0: add_write(ia, PIXEL_W'($urandom));
               1: add_write(ib, PIXEL_W'($urandom));
               2: add_write(ic, PIXEL_W'($urandom));
               default: add_write(id, PIXEL_W'($urandom));
            endcase
         end else if (roll < 92) begin
            add_write($urandom_range(0, FRAME_DEPTH - 1), PIXEL_W'($urandom));
         end else begin
            add_write($urandom_range(FRAME_DEPTH, (1 << INDEX_W) - 1), PIXEL_W'($urandom));
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      request_type item;
      bit          taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            if (req_func == FUNC_WRITE) begin
               if (req_src_index < FRAME_DEPTH) frame_model[req_src_index] = req_src_pixel;
            end else begin
               expected_pixels.push_back(scaled_pixel(req_out_x, req_out_y));
            end
            gap_left = pick_gap();
         end
         if (start && !taken) begin
            // Hold the request until the block takes it.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            item = pending_requests.pop_front();
            req_func      <= item.func;
            req_src_pixel <= item.pixel;
            req_src_index <= item.index;
            req_out_x     <= item.out_x;
            req_out_y     <= item.out_y;
            start         <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic [PIXEL_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_pixels.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("ERROR: unexpected response out_pixel=%h", rsp_out_pixel);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_out_pixel !== want) begin
               if (mismatches < MAX_REPORTS)
                  $display("ERROR: out_pixel expected %h actual %h", want, rsp_out_pixel);
               mismatches++;
            end
         end
      end
   end

endmodule
